// ===== src/mssc_pkg.sv =====
// Shared types, constants and decode functions for the seven-segment clock core.
package mssc_pkg;

    localparam int SCAN_W = 10;
    localparam int SECP_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = 10'd25;
    localparam logic [SECP_W-1:0] SECOND_PERIOD_RST = 16'd100;
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [5:0] SIXTY = 6'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PERIOD = 1'b1;

    typedef struct packed {
        logic [5:0]       seconds;
        logic [5:0]       minutes;
        logic [4:0]       hours;
        logic [SCAN_W-1:0] scan_cd;
        logic [SECP_W-1:0] sec_cd;
        logic             due;
        logic [1:0]       sel;
        logic             dot;
        logic [3:0][3:0]  digits;
        logic [3:0]       enable;
        logic [7:0]       segments;
    } t_state;

    // Tens digit of a value below 64.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // Units digit of a value below 64.
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [6:0] p;
        logic [5:0] r;
        p = 7'({3'd0, tens_of(v)} * 7'd10);
        r = v - p[5:0];
        return r[3:0];
    endfunction

    // Active-low segment code g..a, bit7 high; codes above nine blank.
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'hC0;
            4'd1: s = 8'hF9;
            4'd2: s = 8'hA4;
            4'd3: s = 8'hB0;
            4'd4: s = 8'h99;
            4'd5: s = 8'h92;
            4'd6: s = 8'h82;
            4'd7: s = 8'hF8;
            4'd8: s = 8'h80;
            4'd9: s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

// ===== src/mssc_tick_if.sv =====
// Valid/ready channel carrying one timer tick beat.
interface mssc_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// ===== src/mssc_disp_if.sv =====
// Valid/ready channel carrying one display and time beat.
interface mssc_disp_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_enable;
    logic [7:0] segments;
    logic       dot;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;

    modport source (output valid, output digit_enable, output segments, output dot,
                    output hours, output minutes, output seconds, input ready);
    modport sink (input valid, input digit_enable, input segments, input dot,
                  input hours, input minutes, input seconds, output ready);
endinterface

// ===== src/multiplexed_seven_segment_clock_core.sv =====
// Top level of the multiplexed four-digit seven-segment clock core.
// Each input beat carries one timer tick flag; every beat yields exactly one output beat
// showing the held digit enable (active-low, one-cold once scanning starts), the active-low
// segment code, the colon dot and the hh:mm:ss time after that tick. One beat is taken per
// clock cycle while the output is not stalled. The accepting edge loads the input register;
// a single pass of counter and decode logic then loads the result register once that one is
// free or is being drained, and the result beat is offered from there. The input keeps
// accepting while a result waits, as long as the input register is empty, or the result
// register is free or is drained in the same cycle; with the output stalled, one beat
// waits in each register and the input holds off. Configuration: index 0 is the scan
// period (ticks per digit step), index 1 the second period (ticks until a second is due);
// a new period takes effect at the next reload of its countdown, and a period of zero
// acts as one. Write the periods only while no beat is in flight.
module multiplexed_seven_segment_clock_core
    import mssc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mssc_tick_if.sink             i_tick,
    mssc_disp_if.source           o_disp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    logic              r_in_tick;
    logic              r_out_valid;
    logic [SCAN_W-1:0] r_scan_period;
    logic [SECP_W-1:0] r_second_period;
    t_state            r_state;
    t_state            n_state;
    t_state            r_out;
    t_state            c_rst_state;
    logic              w_adv;
    logic              w_fire;

    // Result register may be loaded when empty or being drained this cycle.
    assign w_adv  = ~r_out_valid | o_disp.ready;
    assign w_fire = r_in_valid & w_adv;
    assign i_tick.ready = ~r_in_valid | w_adv;

    always_comb begin
        c_rst_state = '0;
        c_rst_state.scan_cd = SCAN_PERIOD_RST;
        c_rst_state.sec_cd = SECOND_PERIOD_RST;
        c_rst_state.digits[0] = 4'd6;
        c_rst_state.digits[1] = 4'd7;
        c_rst_state.digits[2] = 4'd8;
        c_rst_state.digits[3] = 4'd9;
        c_rst_state.enable = 4'hF;
        c_rst_state.segments = 8'hFF;
    end

    mssc_step u_step (
        .i_state         (r_state),
        .i_tick          (r_in_tick),
        .i_scan_period   (r_scan_period),
        .i_second_period (r_second_period),
        .o_state         (n_state)
    );

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period <= SCAN_PERIOD_RST;
            r_second_period <= SECOND_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCAN_PERIOD:   r_scan_period <= i_cfg_data[SCAN_W-1:0];
                CFG_SECOND_PERIOD: r_second_period <= i_cfg_data[SECP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold a beat until the step logic can consume it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.valid & i_tick.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid & i_tick.ready) begin
            r_in_tick <= i_tick.tick;
        end
    end

    // Clock state advances once per consumed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c_rst_state;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_disp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_state;
        end
    end

    assign o_disp.valid        = r_out_valid;
    assign o_disp.digit_enable = r_out.enable;
    assign o_disp.segments     = r_out.segments;
    assign o_disp.dot          = r_out.dot;
    assign o_disp.hours        = r_out.hours;
    assign o_disp.minutes      = r_out.minutes;
    assign o_disp.seconds      = r_out.seconds;

    // At most one digit is ever enabled.
    a_one_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_disp.valid |-> ($countones(~o_disp.digit_enable) <= 1))
        else $error("more than one digit enabled");

    // Time stays within a day.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_disp.valid |-> (o_disp.hours < HOURS_PER_DAY && o_disp.minutes < SIXTY
                          && o_disp.seconds < SIXTY))
        else $error("time out of range");

    // A beat without a tick leaves the state untouched.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_in_tick) |=> $stable(r_state))
        else $error("state changed without a tick");

    // A second pending with the countdown parked at zero.
    a_due_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.due |-> (r_state.sec_cd == '0))
        else $error("second due with countdown running");

endmodule

// ===== src/mssc_step.sv =====
// Next-state logic for one tick: countdowns, time advance and digit scan.
module mssc_step
    import mssc_pkg::*;
(
    input  t_state            i_state,
    input  logic              i_tick,
    input  logic [SCAN_W-1:0] i_scan_period,
    input  logic [SECP_W-1:0] i_second_period,
    output t_state            o_state
);

    always_comb begin
        t_state s;
        logic [5:0] sec_inc;
        logic [5:0] min_inc;
        logic [4:0] hr_inc;
        s = i_state;
        sec_inc = s.seconds + 6'd1;
        min_inc = s.minutes + 6'd1;
        hr_inc = s.hours + 5'd1;
        if (i_tick) begin
            if (s.sec_cd <= SECP_W'(1)) begin
                s.sec_cd = '0;
                s.due = 1'b1;
            end else begin
                s.sec_cd = s.sec_cd - SECP_W'(1);
            end
            if (s.scan_cd <= SCAN_W'(1)) begin
                if (s.due) begin
                    // advance hh:mm:ss by one second
                    if (sec_inc >= SIXTY) begin
                        s.seconds = '0;
                        if (min_inc >= SIXTY) begin
                            s.minutes = '0;
                            s.hours = (hr_inc >= HOURS_PER_DAY) ? 5'd0 : hr_inc;
                        end else begin
                            s.minutes = min_inc;
                        end
                    end else begin
                        s.seconds = sec_inc;
                    end
                    s.dot = ~s.dot;
                    s.sec_cd = i_second_period;
                    s.due = 1'b0;
                    s.digits[0] = tens_of({1'b0, s.hours});
                    s.digits[1] = units_of({1'b0, s.hours});
                    s.digits[2] = tens_of(s.minutes);
                    s.digits[3] = units_of(s.minutes);
                end
                s.enable = ~(4'b0001 << s.sel);
                s.segments = seg_code(s.digits[s.sel]);
                s.sel = s.sel + 2'd1;
                s.scan_cd = i_scan_period;
            end else begin
                s.scan_cd = s.scan_cd - SCAN_W'(1);
            end
        end
        o_state = s;
    end

endmodule
